@@ src/assert_macros.svh @@
// Assertion macros used by the text overlay blitter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define TOB_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// Condition must never be true outside reset.
`define TOB_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`endif

@@ src/tob_pkg.sv @@
// Shared constants, types and controller/datapath structs of the overlay blitter.
`default_nettype none

package tob_pkg;

	localparam int PLANE_COLS  = 40;
	localparam int PLANE_ROWS  = 48;
	localparam int FONT_GLYPHS = 64;

	localparam int PLANE_DEPTH  = PLANE_COLS * PLANE_ROWS;
	localparam int PLANE_ADDR_W = $clog2(PLANE_DEPTH);
	localparam int FONT_DEPTH   = 512;
	localparam int FONT_ADDR_W  = $clog2(FONT_DEPTH);

	localparam int OP_W    = 2;
	localparam int X_W     = 10;
	localparam int Y_W     = 6;
	localparam int W_W     = 10;
	localparam int H_W     = 6;
	localparam int CODE_W  = 8;
	localparam int BYTE_W  = 8;
	localparam int COL_W   = X_W - 3;
	localparam int GLYPH_H = 8;
	localparam int GROW_W  = $clog2(GLYPH_H);

	localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;
	localparam logic [CODE_W-1:0] FONT_FIRST_RESET = 8'd32;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_GLYPH = 2'd2,
		OP_READ  = 2'd3
	} tob_op_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic take;
		logic font_wr;
		logic font_rd;
		logic plane_rd;
		logic plane_wr;
		logic second;
		logic init_wr;
		logic row_adv;
		logic col_adv;
		logic res_load;
	} tob_cmd_t;

	// Status from the datapath back to the sequencer.
	typedef struct packed {
		logic    in_valid;
		tob_op_t op;
		logic    init_last;
		logic    read_ok;
		logic    rows_none;
		logic    cols_none;
		logic    glyph_drop;
		logic    spill;
		logic    row_last;
		logic    col_last;
		logic    out_free;
	} tob_sts_t;

endpackage

`default_nettype wire

@@ src/tob_if.sv @@
// Valid/ready channel interfaces: item words, result words, configuration writes.
`default_nettype none

interface tob_item_if import tob_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [X_W-1:0]    x_pixel;
	logic [Y_W-1:0]    y_row;
	logic [W_W-1:0]    rect_width;
	logic [H_W-1:0]    rect_height;
	logic [CODE_W-1:0] glyph_code;
	logic [FONT_ADDR_W-1:0] font_addr;
	logic [BYTE_W-1:0] font_byte;

	modport source (output valid, op, x_pixel, y_row, rect_width, rect_height,
		glyph_code, font_addr, font_byte, input ready);
	modport sink (input valid, op, x_pixel, y_row, rect_width, rect_height,
		glyph_code, font_addr, font_byte, output ready);
endinterface

interface tob_result_if import tob_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] read_data;
	logic              dropped;

	modport source (output valid, read_data, dropped, input ready);
	modport sink (input valid, read_data, dropped, output ready);
endinterface

interface tob_cfg_if import tob_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ src/tob_ctrl.sv @@
// Sequencer of the overlay blitter: init sweep, item dispatch and per-byte read-modify-write.
`default_nettype none

module tob_ctrl import tob_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  tob_sts_t sts,
	output tob_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_DISPATCH,
		S_RD,
		S_WR,
		S_RD2,
		S_WR2,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.init_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.take = 1'b1;
				if (sts.in_valid) begin
					state_nx = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (sts.op)
					OP_LOAD: begin
						cmd.font_wr = 1'b1;
						state_nx    = S_FINISH;
					end
					OP_READ: begin
						cmd.plane_rd = sts.read_ok;
						state_nx     = S_FINISH;
					end
					OP_CLEAR: begin
						state_nx = (sts.cols_none || sts.rows_none) ? S_FINISH : S_RD;
					end
					default: begin
						state_nx = (sts.glyph_drop || sts.rows_none) ? S_FINISH : S_RD;
					end
				endcase
			end
			S_RD: begin
				cmd.plane_rd = 1'b1;
				cmd.font_rd  = 1'b1;
				state_nx     = S_WR;
			end
			S_RD2: begin
				cmd.plane_rd = 1'b1;
				cmd.second   = 1'b1;
				state_nx     = S_WR2;
			end
			S_WR, S_WR2: begin
				cmd.plane_wr = 1'b1;
				cmd.second   = (state_q == S_WR2);
				if (state_q == S_WR && sts.op == OP_GLYPH && sts.spill) begin
					state_nx = S_RD2;
				end else if (!sts.row_last) begin
					cmd.row_adv = 1'b1;
					state_nx    = S_RD;
				end else if (sts.op == OP_CLEAR && !sts.col_last) begin
					cmd.col_adv = 1'b1;
					state_nx    = S_RD;
				end else begin
					state_nx = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

`default_nettype wire

@@ src/tob_dpath.sv @@
// Datapath of the overlay blitter: item registers, counters, plane and font memories, result register.
`default_nettype none

module tob_dpath import tob_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	tob_item_if.sink       items,
	tob_result_if.source   results,
	tob_cfg_if.sink        cfg,
	input  tob_cmd_t       cmd,
	output tob_sts_t       sts
);

	localparam logic [COL_W:0] COLS_C = (COL_W + 1)'(PLANE_COLS);
	localparam logic [Y_W:0]   ROWS_C = (Y_W + 1)'(PLANE_ROWS);
	localparam logic [PLANE_ADDR_W-1:0] ROWS_A = PLANE_ADDR_W'(PLANE_ROWS);

	// Configuration register.
	logic [CODE_W-1:0] first_code_q;

	// Item registers.
	tob_op_t              op_q;
	logic [COL_W-1:0]     first_q;
	logic [2:0]           xlo_q;
	logic [COL_W:0]       last_q;
	logic [2:0]           endlo_q;
	logic                 wzero_q;
	logic [Y_W-1:0]       y_q;
	logic [H_W-1:0]       h_q;
	logic [CODE_W-1:0]    idx_q;
	logic                 code_ok_q;
	logic [FONT_ADDR_W-1:0] fa_q;
	logic [BYTE_W-1:0]    fb_q;

	// Walk counters.
	logic [COL_W-1:0]     col_q;
	logic [H_W-1:0]       r_q;
	logic [PLANE_ADDR_W-1:0] init_addr_q;

	// Memories and their read registers.
	logic [BYTE_W-1:0] plane_mem [PLANE_DEPTH];
	logic [BYTE_W-1:0] font_mem  [FONT_DEPTH];
	logic [BYTE_W-1:0] plane_rdata_q;
	logic [BYTE_W-1:0] font_rdata_q;

	// Result register.
	logic              res_valid_q;
	logic [BYTE_W-1:0] res_data_q;
	logic              res_drop_q;

	logic                 capture;
	logic [X_W:0]         end_px;
	logic [X_W:0]         end_m1;
	logic                 code_ok;
	logic [CODE_W:0]      code_lim;
	logic [Y_W:0]         row;
	logic [COL_W-1:0]     col_sel;
	logic [PLANE_ADDR_W-1:0] cell_addr;
	logic [PLANE_ADDR_W-1:0] plane_waddr;
	logic [BYTE_W-1:0]    plane_wdata;
	logic                 plane_we;
	logic [CODE_W+GROW_W-1:0] glyph_idx;
	logic [FONT_ADDR_W-1:0] font_raddr;
	logic [2*BYTE_W-1:0]  bits;
	logic [BYTE_W-1:0]    lose;
	logic [3:0]           tail_sh;
	logic                 first_bad;
	logic                 rows_out;

	assign capture  = cmd.take && items.valid;
	assign end_px   = {1'b0, items.x_pixel} + {1'b0, items.rect_width};
	assign end_m1   = end_px - (X_W + 1)'(1);
	assign code_lim = {1'b0, first_code_q} + (CODE_W + 1)'(FONT_GLYPHS);
	assign code_ok  = (items.glyph_code >= first_code_q) &&
		({1'b0, items.glyph_code} < code_lim);

	assign items.ready = cmd.take;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_code_q <= FONT_FIRST_RESET;
		end else if (cfg.valid) begin
			first_code_q <= cfg.data;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			op_q      <= tob_op_t'(items.op);
			first_q   <= items.x_pixel[X_W-1:3];
			xlo_q     <= items.x_pixel[2:0];
			last_q    <= end_m1[X_W:3];
			endlo_q   <= end_px[2:0];
			wzero_q   <= (items.rect_width == '0);
			y_q       <= items.y_row;
			h_q       <= items.rect_height;
			idx_q     <= items.glyph_code - first_code_q;
			code_ok_q <= code_ok;
			fa_q      <= items.font_addr;
			fb_q      <= items.font_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			r_q         <= '0;
			init_addr_q <= '0;
		end else begin
			if (capture) begin
				col_q <= items.x_pixel[X_W-1:3];
				r_q   <= '0;
			end else if (cmd.col_adv) begin
				col_q <= col_q + COL_W'(1);
				r_q   <= '0;
			end else if (cmd.row_adv) begin
				r_q <= r_q + H_W'(1);
			end
			if (cmd.init_wr) begin
				init_addr_q <= init_addr_q + PLANE_ADDR_W'(1);
			end
		end
	end

	// Address of the plane byte for the current column (or its right neighbor) and row.
	assign row       = {1'b0, y_q} + {1'b0, r_q};
	assign col_sel   = col_q + COL_W'(cmd.second);
	assign cell_addr = PLANE_ADDR_W'(col_sel) * ROWS_A + PLANE_ADDR_W'(row);

	assign glyph_idx  = {idx_q, r_q[GROW_W-1:0]};
	assign font_raddr = glyph_idx[FONT_ADDR_W-1:0];

	assign bits = {font_rdata_q, {BYTE_W{1'b0}}} >> xlo_q;

	// Clear mask: bits to drop in this column, trimmed at the rectangle edges.
	assign tail_sh = 4'd8 - {1'b0, endlo_q};
	always_comb begin
		lose = BYTE_ONES;
		if (col_q == first_q) begin
			lose = lose & (BYTE_ONES >> xlo_q);
		end
		if ({1'b0, col_q} == last_q && endlo_q != 3'd0) begin
			lose = lose & (BYTE_ONES << tail_sh);
		end
	end

	always_comb begin
		if (cmd.init_wr) begin
			plane_wdata = '0;
		end else if (op_q == OP_CLEAR) begin
			plane_wdata = plane_rdata_q & ~lose;
		end else if (cmd.second) begin
			plane_wdata = plane_rdata_q | bits[BYTE_W-1:0];
		end else begin
			plane_wdata = plane_rdata_q | bits[2*BYTE_W-1:BYTE_W];
		end
	end

	assign plane_we    = cmd.plane_wr || cmd.init_wr;
	assign plane_waddr = cmd.init_wr ? init_addr_q : cell_addr;

	always_ff @(posedge clk) begin
		if (plane_we) begin
			plane_mem[plane_waddr] <= plane_wdata;
		end
		if (cmd.plane_rd) begin
			plane_rdata_q <= plane_mem[cell_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.font_wr) begin
			font_mem[fa_q] <= fb_q;
		end
		if (cmd.font_rd) begin
			font_rdata_q <= font_mem[font_raddr];
		end
	end

	assign first_bad = ({1'b0, first_q} >= COLS_C);
	assign rows_out  = ({1'b0, y_q} >= ROWS_C);

	// Result register: loaded at the end of an item, emptied by the sink.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_data_q <= (op_q == OP_READ && sts.read_ok) ? plane_rdata_q : '0;
			res_drop_q <= (op_q == OP_GLYPH) && sts.glyph_drop;
		end
	end

	assign results.valid     = res_valid_q;
	assign results.read_data = res_data_q;
	assign results.dropped   = res_drop_q;

	always_comb begin
		sts            = '0;
		sts.in_valid   = items.valid;
		sts.op         = op_q;
		sts.init_last  = (init_addr_q == PLANE_ADDR_W'(PLANE_DEPTH - 1));
		sts.read_ok    = !first_bad && !rows_out;
		sts.rows_none  = rows_out || (op_q == OP_CLEAR && h_q == '0);
		sts.cols_none  = wzero_q || first_bad;
		sts.glyph_drop = first_bad || !code_ok_q;
		sts.spill      = (xlo_q != 3'd0) && (({1'b0, first_q} + (COL_W + 1)'(1)) < COLS_C);
		sts.row_last   = (row == ROWS_C - (Y_W + 1)'(1)) ||
			((op_q == OP_CLEAR) ? (r_q == h_q - H_W'(1)) : (r_q == H_W'(GLYPH_H - 1)));
		sts.col_last   = ({1'b0, col_q} == last_q) || (col_q == COL_W'(PLANE_COLS - 1));
		sts.out_free   = !res_valid_q || results.ready;
	end

endmodule

`default_nettype wire

@@ src/text_overlay_glyph_blitter.sv @@
// Top level of the text overlay glyph blitter: sequencer, datapath and checks.
`default_nettype none
`include "assert_macros.svh"

//  Channel   Role   Word carried
//  -------   ----   ---------------------------------------------------------
//  items     sink   op, x_pixel, y_row, rect_width, rect_height, glyph_code, font_addr, font_byte
//  results   source read_data, dropped (one word for every item word)
//  cfg       sink   data: font_first_code, taken in any cycle
//
//  After reset a clearing pass zeroes the 1920 plane bytes, one per cycle; items.ready is low.
//  Load and read items pass straight from dispatch to finish; a glyph reads and then writes one
//  plane byte per row in the plane, or two per row when it spans two columns; a clear does so
//  for each clipped byte. Each plane byte is a read and then a write of the plane memory.
//  A finished result sits in an output register; the next item word is accepted while it waits,
//  and that item's result holds the sequencer in its finish state until the register is free.

module text_overlay_glyph_blitter import tob_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	tob_item_if.sink     items,
	tob_result_if.source results,
	tob_cfg_if.sink      cfg
);

	tob_cmd_t ctl_cmd;
	tob_sts_t dp_sts;

	// The sequencer walks columns and rows of an item and steps the
	// datapath through read, then write, of each plane byte.
	tob_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (dp_sts),
		.cmd    (ctl_cmd)
	);

	// The datapath holds the item fields, both memories, the edge masks,
	// the glyph shifter and the result register.
	tob_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.cfg     (cfg),
		.cmd     (ctl_cmd),
		.sts     (dp_sts)
	);

	// A result is only loaded when the output register can take it.
	`TOB_ASSERT(a_res_load_free, clk, arst_n, ctl_cmd.res_load |-> dp_sts.out_free)

	// Every plane write of an item is the write half of a read in the cycle before.
	`TOB_ASSERT(a_rmw_order, clk, arst_n, ctl_cmd.plane_wr |-> $past(ctl_cmd.plane_rd))

	// A dropped glyph and read data never come in the same word.
	`TOB_NEVER(a_drop_no_data, clk, arst_n,
		results.valid && results.dropped && (results.read_data != '0))

endmodule

`default_nettype wire
